// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Field widths, request and status codes, sequencer states and the result
// record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int PRIO_W    = 16;
	localparam int OCC_W     = 5;
	localparam int STAT_W    = 2;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_REMOVED   = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_REM_HEAD,
		ST_REM_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		status_t                    status;
		logic signed [DATA_W-1:0]   data;
		logic signed [PRIO_W-1:0]   prio;
		logic        [OCC_W-1:0]    occ;
	} result_t;

endpackage

// ===== rtl/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: sorted-list priority queue
// Holds up to DEPTH entries in descending priority order; equal priorities
// leave in arrival order.
//
// Input channel (in_valid/in_ready): req_type selects insert or remove;
// data_value and entry_priority carry the entry to insert.
// Output channel (out_valid/out_ready): one result per request with status,
// the removed entry (zero unless status is removed) and the occupancy after
// the request, taken modulo 32.
//
// One request at a time. The sequencer walks the list through the entry
// memory (one write and one read port), one slot per cycle with one priority
// comparator, so timing is set by the number of entries moved. in_ready is
// low while a request runs.
// The result sits in an output register; a new request is taken while it
// waits, and if the receiver stalls, the following result holds in the
// sequencer, blocking further input until the register frees.
// Reset empties the queue at once (the count goes to zero); the entry
// memory is not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic signed [spq_pkg::DATA_W-1:0]  data_value,
	input  logic signed [spq_pkg::PRIO_W-1:0]  entry_priority,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [spq_pkg::STAT_W-1:0]         status,
	output logic signed [spq_pkg::DATA_W-1:0]  removed_data,
	output logic signed [spq_pkg::PRIO_W-1:0]  removed_priority,
	output logic [spq_pkg::OCC_W-1:0]          occupancy
);
	import spq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic                     wr_en;
	logic [AW-1:0]            wr_addr, rd_addr;
	logic signed [DATA_W-1:0] wr_data, rd_data;
	logic signed [PRIO_W-1:0] wr_prio, rd_prio;
	logic                     res_valid, res_take;
	result_t                  res, out_q;
	logic                     out_valid_q;

	spq_seq #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.data_value     (data_value),
		.entry_priority (entry_priority),
		.res_valid      (res_valid),
		.res_take       (res_take),
		.res            (res),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data),
		.wr_prio        (wr_prio),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.rd_prio        (rd_prio)
	);

	spq_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.wr_prio (wr_prio),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_prio (rd_prio)
	);

	// output register frees when empty or when the current result transfers
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	// load the result payload
	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign removed_data     = out_q.data;
	assign removed_priority = out_q.prio;
	assign occupancy        = out_q.occ;

endmodule

// ===== rtl/spq_store.sv =====
// ----------------------------------------------------------------------------
// spq_store: entry memory
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module spq_store #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [AW-1:0]                      wr_addr,
	input  logic signed [spq_pkg::DATA_W-1:0]  wr_data,
	input  logic signed [spq_pkg::PRIO_W-1:0]  wr_prio,
	input  logic [AW-1:0]                      rd_addr,
	output logic signed [spq_pkg::DATA_W-1:0]  rd_data,
	output logic signed [spq_pkg::PRIO_W-1:0]  rd_prio
);
	import spq_pkg::*;

	logic signed [DATA_W-1:0] data_mem [DEPTH];
	logic signed [PRIO_W-1:0] prio_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_mem[wr_addr] <= wr_data;
			prio_mem[wr_addr] <= wr_prio;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= data_mem[rd_addr];
		rd_prio <= prio_mem[rd_addr];
	end

endmodule

// ===== rtl/spq_seq.sv =====
// ----------------------------------------------------------------------------
// spq_seq: request sequencer
// Walks the stored list one slot per cycle through the entry memory, using a
// single priority comparator, to open a gap on insert or close one on remove.
// ----------------------------------------------------------------------------
module spq_seq #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic signed [spq_pkg::DATA_W-1:0]  data_value,
	input  logic signed [spq_pkg::PRIO_W-1:0]  entry_priority,
	output logic                               res_valid,
	input  logic                               res_take,
	output spq_pkg::result_t                   res,
	output logic                               wr_en,
	output logic [AW-1:0]                      wr_addr,
	output logic signed [spq_pkg::DATA_W-1:0]  wr_data,
	output logic signed [spq_pkg::PRIO_W-1:0]  wr_prio,
	output logic [AW-1:0]                      rd_addr,
	input  logic signed [spq_pkg::DATA_W-1:0]  rd_data,
	input  logic signed [spq_pkg::PRIO_W-1:0]  rd_prio
);
	import spq_pkg::*;

	state_t                   state_q, state_d;
	logic [CW-1:0]            cnt_q, cnt_d;
	logic [CW-1:0]            idx_q, idx_d;
	logic [CW-1:0]            wr_idx, rd_idx;
	logic signed [DATA_W-1:0] item_data_q;
	logic signed [PRIO_W-1:0] item_prio_q;
	result_t                  res_q, res_d;
	logic                     keep_slot;

	// shared comparator: stored entry stays ahead of the new one
	assign keep_slot = (rd_prio >= item_prio_q);

	// state, count and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
		end
	end

	// hold the request and the pending result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_data_q <= data_value;
			item_prio_q <= entry_priority;
		end
		res_q <= res_d;
	end

	// next state and memory control
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		res_d    = res_q;
		wr_en    = 1'b0;
		wr_idx   = idx_q;
		wr_data  = item_data_q;
		wr_prio  = item_prio_q;
		rd_idx   = idx_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_REMOVE) begin
						if (cnt_q == '0) begin
							res_d   = '{STAT_UNDERFLOW, '0, '0, OCC_W'(cnt_q)};
							state_d = ST_DONE;
						end else begin
							rd_idx  = '0;
							state_d = ST_REM_HEAD;
						end
					end else begin
						if (cnt_q == CW'(DEPTH)) begin
							res_d   = '{STAT_OVERFLOW, '0, '0, OCC_W'(cnt_q)};
							state_d = ST_DONE;
						end else if (cnt_q == '0) begin
							// empty list: place at the front at once
							wr_en   = 1'b1;
							wr_idx  = '0;
							wr_data = data_value;
							wr_prio = entry_priority;
							cnt_d   = CW'(1);
							res_d   = '{STAT_INSERTED, '0, '0, OCC_W'(CW'(1))};
							state_d = ST_DONE;
						end else begin
							idx_d   = cnt_q;
							rd_idx  = CW'(cnt_q - CW'(1));
							state_d = ST_INS_CMP;
						end
					end
				end
			end
			ST_INS_CMP: begin
				if (keep_slot) begin
					// gap found: drop the new entry in
					wr_en   = 1'b1;
					cnt_d   = CW'(cnt_q + CW'(1));
					res_d   = '{STAT_INSERTED, '0, '0, OCC_W'(CW'(cnt_q + CW'(1)))};
					state_d = ST_DONE;
				end else begin
					// move the stored entry one slot back
					wr_en   = 1'b1;
					wr_data = rd_data;
					wr_prio = rd_prio;
					idx_d   = CW'(idx_q - CW'(1));
					if (idx_q == CW'(1)) begin
						state_d = ST_INS_PUT;
					end else begin
						rd_idx = CW'(idx_q - CW'(2));
					end
				end
			end
			ST_INS_PUT: begin
				wr_en   = 1'b1;
				cnt_d   = CW'(cnt_q + CW'(1));
				res_d   = '{STAT_INSERTED, '0, '0, OCC_W'(CW'(cnt_q + CW'(1)))};
				state_d = ST_DONE;
			end
			ST_REM_HEAD: begin
				res_d = '{STAT_REMOVED, rd_data, rd_prio, OCC_W'(CW'(cnt_q - CW'(1)))};
				if (cnt_q == CW'(1)) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					idx_d   = CW'(1);
					rd_idx  = CW'(1);
					state_d = ST_REM_SHIFT;
				end
			end
			ST_REM_SHIFT: begin
				// advance the entry one slot toward the front
				wr_en   = 1'b1;
				wr_idx  = CW'(idx_q - CW'(1));
				wr_data = rd_data;
				wr_prio = rd_prio;
				if (CW'(idx_q + CW'(1)) == cnt_q) begin
					cnt_d   = CW'(cnt_q - CW'(1));
					state_d = ST_DONE;
				end else begin
					idx_d  = CW'(idx_q + CW'(1));
					rd_idx = CW'(idx_q + CW'(1));
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign wr_addr   = wr_idx[AW-1:0];
	assign rd_addr   = rd_idx[AW-1:0];
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

endmodule

// ===== tb/sorted_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker: result checker for the sorted priority queue
// Watches both channels, keeps its own sorted list of entries, works out the
// result of every request taken in, and compares each result that leaves
// field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               req_type,
	input  logic signed [spq_pkg::DATA_W-1:0]  data_value,
	input  logic signed [spq_pkg::PRIO_W-1:0]  entry_priority,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [spq_pkg::STAT_W-1:0]         status,
	input  logic signed [spq_pkg::DATA_W-1:0]  removed_data,
	input  logic signed [spq_pkg::PRIO_W-1:0]  removed_priority,
	input  logic [spq_pkg::OCC_W-1:0]          occupancy,
	output int                                 fail_count,
	output int                                 outstanding
);

	import spq_pkg::*;

	// shadow copy of the queue contents, front at slot 0
	logic signed [DATA_W-1:0] held_data [DEPTH];
	logic signed [PRIO_W-1:0] held_prio [DEPTH];
	int                       held_count;

	result_t                  awaited_results [$];
	result_t                  oldest;

	initial begin
		fail_count  = 0;
		outstanding = 0;
		held_count  = 0;
	end

	// apply one request to the shadow list and return the result it must give
	function automatic result_t serve_request(input logic rt,
			input logic signed [DATA_W-1:0] d, input logic signed [PRIO_W-1:0] p);
		result_t r;
		int      pos;
		int      i;
		r.status = STAT_INSERTED;
		r.data   = '0;
		r.prio   = '0;
		if (rt == REQ_REMOVE) begin
			if (held_count == 0) begin
				r.status = STAT_UNDERFLOW;
			end else begin
				r.status = STAT_REMOVED;
				r.data   = held_data[0];
				r.prio   = held_prio[0];
				for (i = 1; i < held_count; i++) begin
					held_data[i-1] = held_data[i];
					held_prio[i-1] = held_prio[i];
				end
				held_count--;
			end
		end else begin
			if (held_count >= DEPTH) begin
				r.status = STAT_OVERFLOW;
			end else begin
				// go past every entry of greater or equal priority
				pos = 0;
				while (pos < held_count && held_prio[pos] >= p)
					pos++;
				for (i = held_count; i > pos; i--) begin
					held_data[i] = held_data[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_data[pos] = d;
				held_prio[pos] = p;
				held_count++;
			end
		end
		r.occ = OCC_W'(held_count);
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	// predict on each input transfer, compare on each output transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(serve_request(req_type, data_value, entry_priority));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d", $time,
						status);
					fail_count++;
				end else begin
					oldest = awaited_results.pop_front();
					check_field("status", {62'd0, oldest.status}, {62'd0, status});
					check_field("removed_data", oldest.data, removed_data);
					check_field("removed_priority", oldest.prio, removed_priority);
					check_field("occupancy", {59'd0, oldest.occ}, {59'd0, occupancy});
				end
			end
			outstanding = awaited_results.size();
		end
	end

endmodule

// ===== tb/sorted_priority_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_test: testbench of the sorted priority queue
// Drives insert and remove requests with random gaps and random output
// stalls: first a directed run through empty, tied, extreme and full cases,
// then bursts that swing the queue between empty and full. A checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_test;

	import spq_pkg::*;

	localparam int RANDOM_REQUESTS = 1800;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      in_valid       = 1'b0;
	logic                      in_ready;
	logic                      req_type       = REQ_INSERT;
	logic signed [DATA_W-1:0]  data_value     = '0;
	logic signed [PRIO_W-1:0]  entry_priority = '0;
	logic                      out_valid;
	logic                      out_ready      = 1'b0;
	logic [STAT_W-1:0]         status;
	logic signed [DATA_W-1:0]  removed_data;
	logic signed [PRIO_W-1:0]  removed_priority;
	logic [OCC_W-1:0]          occupancy;
	int                        fail_count;
	int                        outstanding;
	logic                      steady         = 1'b0;

	sorted_priority_queue_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.data_value       (data_value),
		.entry_priority   (entry_priority),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.removed_data     (removed_data),
		.removed_priority (removed_priority),
		.occupancy        (occupancy)
	);

	sorted_priority_queue_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.data_value       (data_value),
		.entry_priority   (entry_priority),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.removed_data     (removed_data),
		.removed_priority (removed_priority),
		.occupancy        (occupancy),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(12 * 1000000);
		$display("simulation failed");
		$finish;
	end

	// idle length: mostly none, some short, a few long; none in steady bursts
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// priority mix: many ties in a narrow band, some extremes, rest anywhere
	function automatic logic [PRIO_W-1:0] pick_priority();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return PRIO_W'($urandom_range(4) - 2);
		if (r < 45)
			return $urandom_range(1) ? 16'h7FFF : 16'h8000;
		return PRIO_W'($urandom);
	endfunction

	// hold one request on the input channel until it transfers
	task automatic send_request(input logic rt, input logic [DATA_W-1:0] d,
			input logic [PRIO_W-1:0] p);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= rt;
		data_value     <= d;
		entry_priority <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// output side: ready for a cycle, then stall for a random stretch that may be empty
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	initial begin
		int sent;
		int fill_pct;
		int burst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// remove from an empty queue
		send_request(REQ_REMOVE, 32'h1234_5678, 16'h0101);
		// extremes of data and priority, with ties at top, middle and bottom
		send_request(REQ_INSERT, 32'h7FFF_FFFF, 16'h0000);
		send_request(REQ_INSERT, 32'h8000_0000, 16'h0000);
		send_request(REQ_INSERT, 32'h0000_0000, 16'h7FFF);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'h8000);
		send_request(REQ_INSERT, 32'h5555_5555, 16'h7FFF);
		send_request(REQ_INSERT, 32'hAAAA_AAAA, 16'h8000);
		send_request(REQ_INSERT, 32'h0000_0001, 16'hFFFF);
		send_request(REQ_INSERT, 32'h0000_0002, 16'h0001);
		for (int i = 0; i < 8; i++)
			send_request(REQ_INSERT, 32'hC0DE_0000 + i, PRIO_W'((i % 3) - 1));
		// queue is full now: this insert is dropped
		send_request(REQ_INSERT, 32'hDEAD_BEEF, 16'h7FFF);
		// drain the front, including both entries tied at the top
		repeat (6) send_request(REQ_REMOVE, $urandom, PRIO_W'($urandom));

		// bursts that lean toward filling, balancing or draining
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			case ($urandom_range(2))
				0: fill_pct = 85;
				1: fill_pct = 50;
				default: fill_pct = 15;
			endcase
			burst  = $urandom_range(10, 60);
			steady = ($urandom_range(3) == 0);
			repeat (burst) begin
				if ($urandom_range(99) < fill_pct)
					send_request(REQ_INSERT, $urandom, pick_priority());
				else
					send_request(REQ_REMOVE, $urandom, PRIO_W'($urandom));
				sent++;
			end
		end
		in_valid <= 1'b0;

		// let the last results drain, then allow for any stray result
		@(negedge clk);
		wait (outstanding == 0);
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
